/* src/b64sd_pkg.sv */
// Shared types, status codes and the character mapping of the base64 stream decoder.
package b64sd_pkg;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ALIGN  = 2'd1;
    localparam logic [1:0] ST_DECODE = 2'd2;

    localparam logic [1:0] POS_LAST = 2'd3;
    localparam logic [1:0] POS_PAD  = 2'd2;

    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] val;
    } t_sym;

    function automatic t_sym map_char(input logic [7:0] c);
        t_sym s;
        s.bad = 1'b0;
        s.pad = 1'b0;
        s.val = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.val = 6'(c - 8'd65);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.val = 6'(c - 8'd71);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.val = 6'(c + 8'd4);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else if (c == 8'h3D) begin
            s.pad = 1'b1;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

/* src/base64_stream_decoder.sv */
// Base64 stream decoder: character decode, group assembly and result buffer.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | i_valid / o_ready  | i_in_char, i_in_last
//   output   | o_valid / i_ready  | o_out_byte, o_is_status, o_status, o_out_last
//
// One character is taken per cycle. A character that yields results loads up to
// four into the result buffer at once, which drains one per cycle while i_ready is
// high. Such a character is taken once the buffer is empty or its final item leaves
// in the same cycle; characters that yield nothing are taken while it drains, so a
// steady stream runs at one per cycle if i_ready stays high. Results appear in the
// cycle after acceptance. Synchronous active-low reset clears all but the results.
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_status,
    output logic [1:0] o_status,
    output logic       o_out_last
);

    logic [1:0]       r_pos, n_pos;
    logic [17:0]      r_store, n_store;
    logic             r_pad, n_pad;
    logic             r_err, n_err;
    logic [2:0][7:0]  r_byte, n_byte;
    logic [1:0]       r_nbytes, n_nbytes;
    logic [1:0]       r_st, n_st;
    logic [2:0]       r_cnt;
    logic [1:0]       r_sel;
    logic [2:0]       n_total;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_bad;
    logic             w_has_st;
    b64sd_pkg::t_sym  w_sym;

    always_comb begin
        w_sym    = b64sd_pkg::map_char(i_in_char);
        n_pos    = r_pos + 2'd1;
        n_store  = r_store;
        n_pad    = r_pad;
        n_err    = r_err;
        n_byte[0] = {r_store[17:12], r_store[11:10]};
        n_byte[1] = {r_store[9:6], r_store[5:2]};
        n_byte[2] = {r_store[1:0], (w_sym.pad ? 6'd0 : w_sym.val)};
        n_nbytes = 2'd0;
        w_bad    = 1'b0;
        n_st     = b64sd_pkg::ST_OK;
        w_has_st = i_in_last;

        if (!r_err) begin
            if (w_sym.bad) begin
                w_bad = 1'b1;
            end else if (w_sym.pad) begin
                if (r_pos < b64sd_pkg::POS_PAD) begin
                    w_bad = 1'b1;
                end else if (r_pos == b64sd_pkg::POS_PAD) begin
                    n_pad = 1'b1;
                end else if (!i_in_last) begin
                    w_bad = 1'b1;
                end
            end else if (r_pad) begin
                w_bad = 1'b1;
            end else if (r_pos != b64sd_pkg::POS_LAST) begin
                n_store = {r_store[11:0], w_sym.val};
            end

            if (w_bad) begin
                n_err = 1'b1;
            end else if (r_pos == b64sd_pkg::POS_LAST) begin
                if (r_pad) begin
                    n_nbytes = 2'd1;
                end else if (w_sym.pad) begin
                    n_nbytes = 2'd2;
                end else begin
                    n_nbytes = 2'd3;
                end
            end
        end

        if (r_pos == b64sd_pkg::POS_LAST) begin
            n_pad   = 1'b0;
            n_store = '0;
        end

        if (r_pos != b64sd_pkg::POS_LAST) begin
            n_st = b64sd_pkg::ST_ALIGN;
        end else if (n_err) begin
            n_st = b64sd_pkg::ST_DECODE;
        end

        if (i_in_last) begin
            n_pos   = 2'd0;
            n_store = '0;
            n_pad   = 1'b0;
            n_err   = 1'b0;
        end

        n_total = {1'b0, n_nbytes} + {2'b00, w_has_st};
    end

    assign o_ready   = (r_cnt == 3'd0) || (n_total == 3'd0) || ((r_cnt == 3'd1) && i_ready);
    assign w_in_acc  = i_valid && o_ready;
    assign o_valid   = (r_cnt != 3'd0);
    assign w_out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_store <= '0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
            r_cnt   <= 3'd0;
            r_sel   <= 2'd0;
        end else begin
            if (w_in_acc) begin
                r_pos   <= n_pos;
                r_store <= n_store;
                r_pad   <= n_pad;
                r_err   <= n_err;
            end
            if (w_in_acc && (n_total != 3'd0)) begin
                r_cnt <= n_total;
                r_sel <= 2'd0;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt - 3'd1;
                r_sel <= r_sel + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (n_total != 3'd0)) begin
            r_byte   <= n_byte;
            r_nbytes <= n_nbytes;
            r_st     <= n_st;
        end
    end

    always_comb begin
        o_out_byte  = 8'd0;
        o_is_status = 1'b1;
        o_status    = r_st;
        if (r_sel < r_nbytes) begin
            o_is_status = 1'b0;
            o_status    = b64sd_pkg::ST_OK;
            case (r_sel)
                2'd0:    o_out_byte = r_byte[0];
                2'd1:    o_out_byte = r_byte[1];
                default: o_out_byte = r_byte[2];
            endcase
        end
    end

    assign o_out_last = (r_cnt == 3'd1);

`ifndef SYNTHESIS
    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_cnt != 3'd0) && !((r_cnt == 3'd1) && w_out_acc))
            |-> (n_total == 3'd0))
        else $error("Result-producing transaction accepted while results are pending.");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_status) |-> o_out_last)
        else $error("Status item is not the last item of its transaction.");

    a_empty_after_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_is_status && !(w_in_acc && (n_total != 3'd0))) |=> !o_valid)
        else $error("Result buffer not empty after the status item was taken.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("Result count exceeds four.");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_last) |=> ((r_pos == 2'd0) && !r_err && !r_pad))
        else $error("Decoder state not cleared after the final character.");
`endif

endmodule
